### rtl/core/largest_empty_square_finder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the largest empty square finder
// Shared concurrent assertion forms, each clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LARGEST_EMPTY_SQUARE_FINDER_ASSERT_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LESF_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LESF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/lesf_pkg.sv
// ----------------------------------------------------------------------------
// lesf_pkg
// Field widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package lesf_pkg;

    localparam int CELL_W    = 8;
    localparam int SCORE_W   = 11;
    localparam int POS_W     = 10;
    localparam int CFG_W     = 11;
    localparam int OBST_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;

    localparam logic [CFG_W-1:0]  ROW_WIDTH_RESET = 11'd1;
    localparam logic [OBST_W-1:0] OBSTACLE_RESET  = 8'd111;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_WIDTH = 1'd0,
        CFG_OBSTACLE  = 1'd1
    } cfg_index_t;

    // per-cell control flags handed from the front stage to the score stage
    typedef struct packed {
        logic free;
        logic last;
        logic row_end;
        logic first_row;
        logic first_col;
    } item_flags_t;

endpackage

### rtl/core/lesf_if.sv
// ----------------------------------------------------------------------------
// lesf channel interfaces
// Valid/ready channels for map cells in and search results out.
// ----------------------------------------------------------------------------
interface lesf_in_if
    import lesf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cell_char;
    logic              last_cell;

    modport source (output valid, output cell_char, output last_cell, input ready);
    modport sink   (input valid, input cell_char, input last_cell, output ready);
endinterface

interface lesf_out_if
    import lesf_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] square_size;
    logic [POS_W-1:0]   end_row;
    logic [POS_W-1:0]   end_column;

    modport source (output valid, output square_size, output end_row, output end_column,
                    input ready);
    modport sink   (input valid, input square_size, input end_row, input end_column,
                    output ready);
endinterface

### rtl/core/lesf_ram.sv
// ----------------------------------------------------------------------------
// lesf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lesf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/lesf_front.sv
// ----------------------------------------------------------------------------
// lesf_front
// Config registers, raster column/row counters and per-cell classification.
// ----------------------------------------------------------------------------
`include "largest_empty_square_finder_assert.svh"

module lesf_front
    import lesf_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_fire,
    input  logic [CELL_W-1:0]    cell_char,
    input  logic                 last_cell,
    output logic [COL_W-1:0]     issue_col,
    output logic [ROW_W-1:0]     issue_row,
    output item_flags_t          issue_flags
);

    localparam int WID_W = $clog2(MAX_COLS + 1);
    localparam int CMP_W = (WID_W > CFG_W) ? WID_W : CFG_W;

    logic [CFG_W-1:0]  row_width_reg;
    logic [OBST_W-1:0] obstacle_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;

    logic [CMP_W-1:0]  width_ext;
    logic [CMP_W-1:0]  eff_width;
    logic [COL_W-1:0]  last_col;
    logic [COL_W-1:0]  col_clamped;
    logic              row_end;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
            obstacle_reg  <= OBSTACLE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ROW_WIDTH: row_width_reg <= cfg_data;
                CFG_OBSTACLE:  obstacle_reg  <= cfg_data[OBST_W-1:0];
                default:       ;
            endcase
        end
    end

    // zero width acts as one, oversize width is capped at the buffer size
    always_comb
    begin
        width_ext = CMP_W'(row_width_reg);
        if (width_ext == '0)
        begin
            eff_width = CMP_W'(1);
        end
        else if (width_ext > CMP_W'(MAX_COLS))
        begin
            eff_width = CMP_W'(MAX_COLS);
        end
        else
        begin
            eff_width = width_ext;
        end
        last_col    = COL_W'(eff_width - CMP_W'(1));
        col_clamped = (col_reg >= last_col) ? last_col : col_reg;
        row_end     = (col_clamped == last_col);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_fire)
        begin
            if (last_cell)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                if (row_reg != ROW_W'(MAX_ROWS - 1))
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_clamped + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign issue_col             = col_clamped;
    assign issue_row             = row_reg;
    assign issue_flags.free      = (cell_char != obstacle_reg);
    assign issue_flags.last      = last_cell;
    assign issue_flags.row_end   = row_end;
    assign issue_flags.first_row = (row_reg == '0);
    assign issue_flags.first_col = (col_clamped == '0);

    `LESF_ASSERT_NEXT(a_last_restarts_map, clk, rst_n, in_fire && last_cell,
        col_reg == '0 && row_reg == '0, "map did not restart after last cell")
    `LESF_ASSERT_NEXT(a_row_end_wraps, clk, rst_n, in_fire && row_end,
        col_reg == '0, "column did not wrap at row end")

endmodule

### rtl/core/lesf_score.sv
// ----------------------------------------------------------------------------
// lesf_score
// Score stage: upper-score forwarding, square DP, best tracking, result reg.
// ----------------------------------------------------------------------------
`include "largest_empty_square_finder_assert.svh"

module lesf_score
    import lesf_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    output logic               in_ready,
    input  logic [COL_W-1:0]   issue_col,
    input  logic [ROW_W-1:0]   issue_row,
    input  item_flags_t        issue_flags,
    input  logic [SCORE_W-1:0] up_rd_data,
    output logic               wr_en,
    output logic [COL_W-1:0]   wr_addr,
    output logic [SCORE_W-1:0] wr_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SCORE_W-1:0] square_size,
    output logic [POS_W-1:0]   end_row,
    output logic [POS_W-1:0]   end_column
);

    logic               s1_valid_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    item_flags_t        s1_flags_reg;
    logic               fwd_hit_reg;
    logic [SCORE_W-1:0] fwd_data_reg;
    logic [SCORE_W-1:0] left_reg;
    logic [SCORE_W-1:0] diag_reg;
    logic [SCORE_W-1:0] best_size_reg;
    logic [ROW_W-1:0]   best_row_reg;
    logic [COL_W-1:0]   best_col_reg;
    logic               out_valid_reg;
    logic [SCORE_W-1:0] out_size_reg;
    logic [POS_W-1:0]   out_row_reg;
    logic [POS_W-1:0]   out_col_reg;

    logic               s1_hold;
    logic               s1_fire;
    logic [SCORE_W-1:0] up_score;
    logic [SCORE_W-1:0] min_lu;
    logic [SCORE_W-1:0] min_all;
    logic [SCORE_W-1:0] score;
    logic               better;
    logic [SCORE_W-1:0] cand_size;
    logic [ROW_W-1:0]   cand_row;
    logic [COL_W-1:0]   cand_col;
    logic [POS_W+ROW_W-1:0] row_ext;
    logic [POS_W+COL_W-1:0] col_ext;

    // a last cell waits here while the previous result is still unread
    assign s1_hold  = s1_valid_reg && s1_flags_reg.last && out_valid_reg && !out_ready;
    assign s1_fire  = s1_valid_reg && !s1_hold;
    assign in_ready = !s1_hold;

    always_comb
    begin
        if (s1_flags_reg.first_row)
        begin
            up_score = '0;
        end
        else if (fwd_hit_reg)
        begin
            up_score = fwd_data_reg;
        end
        else
        begin
            up_score = up_rd_data;
        end
        min_lu  = (up_score < left_reg) ? up_score : left_reg;
        min_all = (diag_reg < min_lu) ? diag_reg : min_lu;
        if (!s1_flags_reg.free)
        begin
            score = '0;
        end
        else if (s1_flags_reg.first_row || s1_flags_reg.first_col)
        begin
            score = SCORE_W'(1);
        end
        else
        begin
            score = min_all + SCORE_W'(1);
        end
        better    = (score > best_size_reg);
        cand_size = better ? score      : best_size_reg;
        cand_row  = better ? s1_row_reg : best_row_reg;
        cand_col  = better ? s1_col_reg : best_col_reg;
        row_ext   = {{POS_W{1'b0}}, cand_row};
        col_ext   = {{POS_W{1'b0}}, cand_col};
    end

    assign wr_en   = s1_fire;
    assign wr_addr = s1_col_reg;
    assign wr_data = score;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                // the write landing this edge is missed by the RAM read
                fwd_hit_reg  <= s1_fire && (s1_col_reg == issue_col);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_col_reg   <= issue_col;
            s1_row_reg   <= issue_row;
            s1_flags_reg <= issue_flags;
            fwd_data_reg <= score;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            diag_reg      <= '0;
            best_size_reg <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
        end
        else if (s1_fire)
        begin
            if (s1_flags_reg.last || s1_flags_reg.row_end)
            begin
                left_reg <= '0;
                diag_reg <= '0;
            end
            else
            begin
                left_reg <= score;
                diag_reg <= up_score;
            end
            if (s1_flags_reg.last)
            begin
                best_size_reg <= '0;
                best_row_reg  <= '0;
                best_col_reg  <= '0;
            end
            else
            begin
                best_size_reg <= cand_size;
                best_row_reg  <= cand_row;
                best_col_reg  <= cand_col;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_flags_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_flags_reg.last)
        begin
            out_size_reg <= cand_size;
            out_row_reg  <= row_ext[POS_W-1:0];
            out_col_reg  <= col_ext[POS_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign square_size = out_size_reg;
    assign end_row     = out_row_reg;
    assign end_column  = out_col_reg;

    `LESF_ASSERT_SAME(a_hold_blocks_input, clk, rst_n,
        s1_valid_reg && s1_flags_reg.last && out_valid_reg && !out_ready,
        !in_ready, "input open while a result is blocked")
    `LESF_ASSERT_NEXT(a_forward_same_col, clk, rst_n,
        in_fire && s1_fire && (s1_col_reg == issue_col),
        fwd_hit_reg, "same-column write not forwarded")
    `LESF_ASSERT_SAME(a_blocked_scores_zero, clk, rst_n,
        s1_fire && !s1_flags_reg.free, wr_data == '0, "blocked cell scored nonzero")

endmodule

### rtl/core/largest_empty_square_finder.sv
// ----------------------------------------------------------------------------
// largest_empty_square_finder
// Streams a character map in raster order and reports its largest free square.
// ----------------------------------------------------------------------------
// The block takes one map cell per beat on cell_in, in raster order, and
// accepts a cell every clock cycle. A cell whose character matches the
// obstacle register is blocked; every other cell is free. Each cell gets the
// classic maximal-square score, and the previous row's scores live in a
// MAX_COLS-deep line buffer RAM (one read and one write per cell). The
// largest score is kept with the row and column of its bottom-right cell,
// the first one in raster order winning ties. On the beat marked last_cell
// one result beat appears on result_out as that cell leaves the score stage
// (size 0 at row 0, column 0 if the map had no free cell), and the tracker
// and counters restart for the next map. Input stalls only when a last cell
// reaches the score stage while the previous result still sits unread in
// the output register. Configuration (row_width, obstacle_char) is written
// through cfg_we/cfg_index/cfg_data between maps. A row_width of 0 acts as 1,
// one above MAX_COLS acts as MAX_COLS, and the row count saturates at
// MAX_ROWS-1. The line buffer needs no clearing after reset: each row only
// reads entries that the row above has written.
//
// Pipeline:
//   front  - config regs, column/row counters, obstacle compare, RAM read
//            issued at the accept edge
//   score  - upper score from RAM or from the write-to-read forwarding
//            register (a row of width one reads back what was written in
//            the same edge), min-of-three + 1, best tracking, result reg
// ----------------------------------------------------------------------------
module largest_empty_square_finder
    import lesf_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    lesf_in_if.sink              cell_in,
    lesf_out_if.source           result_out
);

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic               in_fire;
    logic               in_ready;
    logic [COL_W-1:0]   issue_col;
    logic [ROW_W-1:0]   issue_row;
    item_flags_t        issue_flags;
    logic [SCORE_W-1:0] up_rd_data;
    logic               wr_en;
    logic [COL_W-1:0]   wr_addr;
    logic [SCORE_W-1:0] wr_data;

    assign in_fire       = cell_in.valid && in_ready;
    assign cell_in.ready = in_ready;

    lesf_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_fire     (in_fire),
        .cell_char   (cell_in.cell_char),
        .last_cell   (cell_in.last_cell),
        .issue_col   (issue_col),
        .issue_row   (issue_row),
        .issue_flags (issue_flags)
    );

    // line buffer: previous row's scores, read at accept, written at score
    lesf_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (MAX_COLS)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (in_fire),
        .rd_addr (issue_col),
        .rd_data (up_rd_data)
    );

    lesf_score #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_score (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .in_ready    (in_ready),
        .issue_col   (issue_col),
        .issue_row   (issue_row),
        .issue_flags (issue_flags),
        .up_rd_data  (up_rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .out_valid   (result_out.valid),
        .out_ready   (result_out.ready),
        .square_size (result_out.square_size),
        .end_row     (result_out.end_row),
        .end_column  (result_out.end_column)
    );

endmodule
